### rtl/pfd_pkg.sv
// Shared types, constants and helper functions for the Playfair digraph cipher.
// Used by every module of the block; depends on nothing else.
package pfd_pkg;

	// Side of the key square and width of one letter code.
	localparam int SIDE = 5;
	localparam int LW = 5;
	localparam int ROW_W = SIDE * LW;
	localparam int IDX_W = 3;

	// Letter used for padding and for splitting doubled pairs.
	localparam logic [LW-1:0] FILLER_CODE = 5'd23;

	// Default depth of the digraph queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ROW_4 = 3'd5;

	// Mode codes.
	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	// Input item.
	typedef struct packed {
		logic [LW-1:0] letter;
		logic          final_letter;
	} letter_item_t;

	// Result item.
	typedef struct packed {
		logic [LW-1:0] out_first;
		logic [LW-1:0] out_second;
		logic          bad_letter;
		logic          last_pair;
	} pair_item_t;

	// One digraph waiting for lookup.
	typedef struct packed {
		logic [LW-1:0] first;
		logic [LW-1:0] second;
		logic          last;
	} digraph_t;

	// Push request from the front into the queue; second_en only with first_en.
	typedef struct packed {
		logic     first_en;
		logic     second_en;
		digraph_t first;
		digraph_t second;
	} fq_push_t;

	// Position of a letter in the square.
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} loc_t;

	// The whole key square, row r holds column c at bits c*5 +: 5.
	typedef logic [SIDE-1:0][ROW_W-1:0] square_t;

	// Letter at a given row and column.
	function automatic logic [LW-1:0] square_at(square_t sq, logic [IDX_W-1:0] r,
	                                            logic [IDX_W-1:0] c);
		return sq[r][int'(c) * LW +: LW];
	endfunction

	// First position of a code in row-major order; 25 parallel compares.
	function automatic loc_t locate(square_t sq, logic [LW-1:0] code);
		loc_t res;
		res = '0;
		for (int r = SIDE - 1; r >= 0; r--) begin
			for (int c = SIDE - 1; c >= 0; c--) begin
				if (sq[r][c * LW +: LW] == code) begin
					res.found = 1'b1;
					res.row = IDX_W'(r);
					res.col = IDX_W'(c);
				end
			end
		end
		return res;
	endfunction

	// Wrapping step of a row or column index: forward when encrypting, back when decrypting.
	function automatic logic [IDX_W-1:0] step_idx(logic [IDX_W-1:0] idx, logic dec);
		logic [IDX_W-1:0] res;
		if (dec) begin
			res = (idx == '0) ? IDX_W'(SIDE - 1) : idx - 1'b1;
		end else begin
			res = (idx == IDX_W'(SIDE - 1)) ? '0 : idx + 1'b1;
		end
		return res;
	endfunction

endpackage

### rtl/pfd_front.sv
// Front end of the Playfair cipher: accepts letters, pairs them into digraphs.
// Handles doubled pairs and lone final letters. Depends on pfd_pkg.
module pfd_front import pfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         letter_valid,
	output logic         letter_ready,
	input  letter_item_t letter_data,
	input  logic         mode,
	input  logic         room2,
	output fq_push_t     push
);

	logic          held_valid_q;
	logic [LW-1:0] held_letter_q;
	logic          accept;
	logic          doubled;

	// Items are taken whenever the queue has room for two digraphs.
	assign letter_ready = room2;
	assign accept = letter_valid && room2;
	assign doubled = (mode == MODE_ENCRYPT) && (held_letter_q == letter_data.letter);

	// Classify the item and build the digraphs it completes.
	always_comb begin
		push = '0;
		if (accept) begin
			if (!held_valid_q) begin
				if (letter_data.final_letter) begin
					push.first_en = 1'b1;
					push.first = '{letter_data.letter, FILLER_CODE, 1'b1};
				end
			end else if (doubled) begin
				push.first_en = 1'b1;
				push.first = '{held_letter_q, FILLER_CODE, 1'b0};
				if (letter_data.final_letter) begin
					push.second_en = 1'b1;
					push.second = '{letter_data.letter, FILLER_CODE, 1'b1};
				end
			end else begin
				push.first_en = 1'b1;
				push.first = '{held_letter_q, letter_data.letter, letter_data.final_letter};
			end
		end
	end

	// Held letter: a non-final letter is held when nothing else is held,
	// or when it splits a doubled pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_letter_q <= '0;
		end else if (accept) begin
			held_letter_q <= letter_data.letter;
			if (!held_valid_q || doubled) begin
				held_valid_q <= !letter_data.final_letter;
			end else begin
				held_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/pfd_queue.sv
// Short digraph queue between the front and the back of the Playfair cipher.
// Takes up to two digraphs and gives one per cycle when popped. Depends on pfd_pkg.
module pfd_queue import pfd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  fq_push_t push,
	input  logic     pop,
	output logic     room2,
	output logic     head_valid,
	output digraph_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	digraph_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   wr_next;

	function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_next = inc(wr_ptr_q);
	assign room2 = count_q <= CW'(DEPTH - 2);
	assign head_valid = count_q != '0;
	assign head = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.first_en) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.second_en) begin
			mem_q[wr_next] <= push.second;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.second_en) begin
				wr_ptr_q <= inc(wr_next);
			end else if (push.first_en) begin
				wr_ptr_q <= wr_next;
			end
			if (pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.first_en) + CW'(push.second_en) - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.first_en |-> room2)
		else $error("push without room");
	a_second_with_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.second_en |-> push.first_en)
		else $error("second push without first");
`endif

endmodule

### rtl/pfd_back.sv
// Back end of the Playfair cipher: square lookup and digraph transform.
// Two stages (locate, substitute) with an output register. Depends on pfd_pkg.
module pfd_back import pfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  digraph_t   head,
	output logic       pop,
	input  logic       mode,
	input  square_t    square,
	output logic       pair_valid,
	input  logic       pair_ready,
	output pair_item_t pair_data
);

	logic       valid_s1;
	loc_t       loc_a_s1;
	loc_t       loc_b_s1;
	logic       last_s1;
	logic       out_valid_q;
	pair_item_t out_data_q;
	logic       out_free;
	logic       s1_adv;
	pair_item_t result;

	// Stall chain from the output register back to the queue.
	assign out_free = !out_valid_q || pair_ready;
	assign s1_adv = !valid_s1 || out_free;
	assign pop = head_valid && s1_adv;

	// Substitution from the located positions.
	always_comb begin
		result = '0;
		result.last_pair = last_s1;
		if (!loc_a_s1.found || !loc_b_s1.found) begin
			result.bad_letter = 1'b1;
		end else if (loc_a_s1.row == loc_b_s1.row) begin
			result.out_first = square_at(square, loc_a_s1.row, step_idx(loc_a_s1.col, mode));
			result.out_second = square_at(square, loc_a_s1.row, step_idx(loc_b_s1.col, mode));
		end else if (loc_a_s1.col == loc_b_s1.col) begin
			result.out_first = square_at(square, step_idx(loc_a_s1.row, mode), loc_a_s1.col);
			result.out_second = square_at(square, step_idx(loc_b_s1.row, mode), loc_a_s1.col);
		end else begin
			result.out_first = square_at(square, loc_a_s1.row, loc_b_s1.col);
			result.out_second = square_at(square, loc_b_s1.row, loc_a_s1.col);
		end
	end

	// Valid bits of the locate stage and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= head_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			loc_a_s1 <= locate(square, head.first);
			loc_b_s1 <= locate(square, head.second);
			last_s1 <= head.last;
		end
		if (out_free && valid_s1) begin
			out_data_q <= result;
		end
	end

	assign pair_valid = out_valid_q;
	assign pair_data = out_data_q;

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.bad_letter) |->
		(out_data_q.out_first == '0 && out_data_q.out_second == '0))
		else $error("bad digraph with nonzero letters");
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> valid_s1)
		else $error("locate stage dropped an item under stall");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pair_ready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("result item changed while waiting");
`endif

endmodule

### rtl/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: configuration registers and the
// front, queue and back parts. Depends on pfd_pkg, pfd_front, pfd_queue, pfd_back.
//
// Usage:
//   Letters (A=0..Z=25) enter on letter_valid/letter_ready/letter_data and
//   digraph results leave on pair_valid/pair_ready/pair_data, each one item per
//   cycle while ready; final_letter marks the last letter of a message.
//   Configuration (mode, key rows 0..4) is written through cfg_we, cfg_index and
//   cfg_data while the block is idle; a write takes effect at once.
//   A completed digraph is written to the queue, then registered in the locate
//   stage and the output register. Throughput is one letter per cycle while
//   letter_ready is high; a final letter that doubles the held letter in encrypt
//   mode produces two results from one letter, and the back end emits one result
//   a cycle unless stalled, so the queue depth sets how long bursts are absorbed.
//   letter_ready is high while the queue has room for two digraphs.
//   When the receiver stalls, the output register holds its item, the locate
//   stage and then the queue fill, and letter_ready drops.
//   Reset clears the held letter, the queue, the pipeline, mode (encrypt) and
//   all key rows to zero. There is no clearing pass.
module playfair_digraph_cipher import pfd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 letter_valid,
	output logic                 letter_ready,
	input  letter_item_t         letter_data,
	output logic                 pair_valid,
	input  logic                 pair_ready,
	output pair_item_t           pair_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]     cfg_data
);

	logic     mode_q;
	square_t  square_q;
	fq_push_t push;
	logic     room2;
	logic     head_valid;
	digraph_t head;
	logic     pop;

	// Configuration registers; indexes past the last key row are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCRYPT;
			square_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_MODE) begin
				mode_q <= cfg_data[0];
			end else if (cfg_index >= REG_KEY_ROW_0 && cfg_index <= REG_KEY_ROW_4) begin
				square_q[cfg_index - REG_KEY_ROW_0] <= cfg_data;
			end
		end
	end

	pfd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.letter_valid (letter_valid),
		.letter_ready (letter_ready),
		.letter_data  (letter_data),
		.mode         (mode_q),
		.room2        (room2),
		.push         (push)
	);

	pfd_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.room2      (room2),
		.head_valid (head_valid),
		.head       (head)
	);

	pfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.mode       (mode_q),
		.square     (square_q),
		.pair_valid (pair_valid),
		.pair_ready (pair_ready),
		.pair_data  (pair_data)
	);

endmodule
